// ===== rtl/core/ils_pkg.sv =====
`default_nettype none
package ils_pkg;

  localparam int DEF_CAPACITY = 256;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 10;
  localparam int LEN_W        = 9;
  // wide enough for any cell index or fill count up to the largest capacity
  localparam int CMD_POS_W    = 13;

  localparam logic [2:0] OP_GET  = 3'd0;
  localparam logic [2:0] OP_HEAD = 3'd1;
  localparam logic [2:0] OP_TAIL = 3'd2;
  localparam logic [2:0] OP_AT   = 3'd3;
  localparam logic [2:0] OP_DEL  = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]              opcode;
    logic [POS_W-1:0]        position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]              status;
    logic [LEN_W-1:0]        length;
  } rsp_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic                     get;
    logic                     ins;
    logic                     del;
    logic [CMD_POS_W-1:0]     pos;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/ils_cell.sv =====
`default_nettype none
module ils_cell #(
  parameter int INDEX = 0
) (
  input  logic                              clk,
  input  ils_pkg::cell_cmd_t                cmd,
  input  logic signed [ils_pkg::DATA_W-1:0] left,
  input  logic signed [ils_pkg::DATA_W-1:0] right,
  output logic signed [ils_pkg::DATA_W-1:0] data,
  output logic signed [ils_pkg::DATA_W-1:0] tap
);
  import ils_pkg::*;

  logic hit;
  logic after;

  assign hit   = (int'(cmd.pos) == INDEX);
  assign after = (INDEX > int'(cmd.pos));

  // insert: take the left neighbor behind the position, the new word at it;
  // delete: take the right neighbor from the position on
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (after) begin
        data <= left;
      end else if (hit) begin
        data <= cmd.value;
      end
    end else if (cmd.del && (hit || after)) begin
      data <= right;
    end
    tap <= (cmd.get && hit) ? data : '0;
  end

endmodule
`default_nettype wire

// ===== rtl/core/indexed_list_store_unit.sv =====
`default_nettype none
// Indexed list store: an ordered sequence of up to CAPACITY signed 32-bit
// words kept in a row of cells, one word per cell.
// Request channel (req_valid / req_stall / req): opcode, position, value.
// A beat is taken when req_valid is high and req_stall is low.
// Response channel (rsp_valid / rsp_stall / rsp): read_value, status and
// the length after the request; exactly one response beat per request.
// Timing: a request is decoded and the cells from its position on shift by
// one cell in the cycle after acceptance (insert or delete), then the get
// word is gathered through a two-level registered OR tree over the cell
// taps, groups of GROUP cells first, into the response register. A new
// request is taken only once the last one has reached the response register.
// The response register parts the two sides: a new request is taken while
// an older response still waits. If the receiver stalls, the response
// holds, and a finished request waits before the response register until
// that is free, with req_stall high.
// Reset: length returns to zero and the channels go idle. Cell contents are
// not cleared; only cells below the length are ever read.
module indexed_list_store_unit #(
  parameter int CAPACITY = ils_pkg::DEF_CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ils_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ils_pkg::rsp_t rsp
);
  import ils_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int GROUP = 16;
  localparam int NG    = (CAPACITY + GROUP - 1) / GROUP;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_TREE, S_DONE} state_t;

  state_t                   state;
  req_t                     req_q;
  logic [CNT_W-1:0]         count;
  logic                     rd_ok;
  logic [1:0]               st_q;

  logic [CMD_POS_W-1:0]     cnt_ext;
  logic [CMD_POS_W-1:0]     pos_ext;
  logic [CMD_POS_W-1:0]     ins_pos;
  logic                     full;
  logic [1:0]               st_next;
  logic                     do_ins;
  logic                     do_del;
  logic                     do_get;
  logic [CNT_W-1:0]         count_next;
  cell_cmd_t                cmd;

  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic signed [DATA_W-1:0] cell_tap  [CAPACITY];
  logic signed [DATA_W-1:0] grp_next  [NG];
  logic signed [DATA_W-1:0] grp       [NG];
  logic signed [DATA_W-1:0] gathered;
  logic                     rsp_free;

  assign req_stall = (state != S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  assign cnt_ext = CMD_POS_W'(count);
  assign pos_ext = CMD_POS_W'(req_q.position);
  assign full    = (count == CNT_W'(CAPACITY));

  // Decode the held request against the current length.
  always_comb begin
    st_next    = ST_DONE;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    do_get     = 1'b0;
    ins_pos    = pos_ext;
    count_next = count;
    case (req_q.opcode)
      OP_GET: begin
        if (pos_ext < cnt_ext) begin
          do_get = 1'b1;
        end else begin
          st_next = ST_RANGE;
        end
      end
      OP_HEAD, OP_TAIL, OP_AT: begin
        if (req_q.opcode == OP_HEAD) begin
          ins_pos = '0;
        end else if (req_q.opcode == OP_TAIL) begin
          ins_pos = cnt_ext;
        end
        // range check comes before the full check
        if (ins_pos > cnt_ext) begin
          st_next = ST_RANGE;
        end else if (full) begin
          st_next = ST_FULL;
        end else begin
          do_ins     = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      OP_DEL: begin
        if (pos_ext >= cnt_ext) begin
          st_next = ST_RANGE;
        end else begin
          do_del     = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        st_next = ST_DONE;
      end
    endcase
  end

  // Broadcast the command to the row only in the execute cycle.
  always_comb begin
    cmd.get   = (state == S_EXEC) && do_get;
    cmd.ins   = (state == S_EXEC) && do_ins;
    cmd.del   = (state == S_EXEC) && do_del;
    cmd.pos   = do_ins ? ins_pos : pos_ext;
    cmd.value = req_q.value;
  end

  // Row of cells; the ends see zero from the missing neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_w;
    logic signed [DATA_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner_r
      assign right_w = cell_data[i+1];
    end
    ils_cell #(.INDEX(i)) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .left  (left_w),
      .right (right_w),
      .data  (cell_data[i]),
      .tap   (cell_tap[i])
    );
  end

  // First tree level: OR the taps of each group; at most one tap is nonzero.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < CAPACITY) begin
          grp_next[g] = grp_next[g] | cell_tap[g * GROUP + k];
        end
      end
    end
  end

  // capture the group words once, then hold them while the response waits
  always_ff @(posedge clk) begin
    if (state == S_TREE) begin
      for (int g = 0; g < NG; g++) begin
        grp[g] <= grp_next[g];
      end
    end
  end

  // Second tree level feeds the response register.
  always_comb begin
    gathered = '0;
    for (int g = 0; g < NG; g++) begin
      gathered = gathered | grp[g];
    end
  end

  // Sequencer, length and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // drop the response once the receiver takes it
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q <= req;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          st_q  <= st_next;
          rd_ok <= do_get;
          count <= count_next;
          state <= S_TREE;
        end
        S_TREE: begin
          state <= S_DONE;
        end
        S_DONE: begin
          // hold until the response register is free
          if (rsp_free) begin
            rsp_valid       <= 1'b1;
            rsp.read_value  <= rd_ok ? gathered : '1;
            rsp.status      <= st_q;
            rsp.length      <= LEN_W'(count);
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ils_checker.sv =====
`default_nettype none
module ils_checker #(
  parameter int CAPACITY = ils_pkg::DEF_CAPACITY
) (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input ils_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input ils_pkg::rsp_t rsp
);
  import ils_pkg::*;

  // a stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // an ignored request never carries data
  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_DONE) |-> (rsp.read_value == -1))
    else $error("failed request returned data");

  // a full report comes only with the store at capacity
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FULL) |-> (rsp.length == LEN_W'(CAPACITY)))
    else $error("full status with length below capacity");

  // the block is busy in the cycle after taking a request
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken in back-to-back cycles");

endmodule

bind indexed_list_store_unit ils_checker #(.CAPACITY(CAPACITY)) u_ils_checker (.*);
`default_nettype wire
